// File: design/encoder_speed_p_controller_top_assert.svh
// Assertion macros used by the speed controller top level.
`ifndef ENCODER_SPEED_P_CONTROLLER_TOP_ASSERT_SVH
`define ENCODER_SPEED_P_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/esp_pkg.sv
// Types, codes and constants of the encoder speed controller.
package esp_pkg;

   localparam logic [1:0] OP_EDGE   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_BUTTON = 2'd2;

   localparam logic [1:0] CSR_SETPOINT = 2'd0;
   localparam logic [1:0] CSR_KP       = 2'd1;
   localparam logic [1:0] CSR_SCALE    = 2'd2;
   localparam logic [1:0] CSR_RANGE    = 2'd3;

   localparam logic signed [15:0] SETPOINT_RESET = 16'sd461;
   localparam logic [15:0]        KP_RESET       = 16'd256;
   localparam logic [15:0]        SCALE_RESET    = 16'd2402;
   localparam logic [9:0]         RANGE_RESET    = 10'd100;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic [1:0] op;
      logic       b_level;
      logic       button_level;
   } esp_req_type;

   typedef struct packed {
      logic [9:0]         duty;
      logic               direction;
      logic               enabled;
      logic signed [15:0] measured_speed;
      logic signed [23:0] speed_error;
      logic signed [23:0] drive;
   } esp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPEED,
      ST_GAIN,
      ST_DRIVE,
      ST_SCALE,
      ST_DUTY,
      ST_DONE
   } esp_state_type;

   typedef struct packed {
      logic busy;
      logic speed_en;
      logic mul_scale;
      logic drive_en;
      logic duty_en;
      logic rsp_load;
   } esp_ctrl_type;

endpackage

// File: design/encoder_speed_p_controller_top.sv
// Top level of the encoder speed controller: state, datapath and ports.
//
//   Channel | Handshake           | Beat
//   --------+---------------------+-------------------------------------------
//   req     | req_valid/req_stall | op, b_level, button_level
//   rsp     | rsp_valid/rsp_stall | duty, direction, enabled, speed, error, drive
//   csr     | csr_valid/csr_ready | csr_index, csr_wdata (always ready)
//
// An encoder edge, a non-toggling button sample or an unused op goes to done;
// a sample tick steps through speed, gain, drive, scale and duty, and a toggling
// press skips speed; the two passes through the shared multiplier are gain and scale.
// Reset is synchronous, restores the default gains and clears all state but the response data.
// A result waits in the output register while the next beat is accepted; only
// the final load waits for rsp_stall to fall.
module encoder_speed_p_controller_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esp_pkg::esp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esp_pkg::esp_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   `include "encoder_speed_p_controller_top_assert.svh"

   esp_pkg::esp_ctrl_type ctrl;

   logic signed [15:0] setpoint_ff;
   logic [15:0]        kp_ff;
   logic [15:0]        scale_ff;
   logic [9:0]         range_ff;

   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        last_ff;
   logic               enable_ff, enable_in;
   logic               press_ff, press_in;
   logic signed [15:0] speed_ff, speed_in;
   logic signed [23:0] error_ff, error_in;
   logic signed [23:0] drive_ff, drive_in;
   logic [9:0]         duty_ff, duty_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   esp_pkg::esp_rsp_type rsp_data_ff;

   logic signed [esp_pkg::MUL_P_W-1:0] prod;

   logic        accept;
   logic        toggle;
   logic        rsp_free;
   logic signed [31:0] diff;
   logic signed [25:0] err_wide;
   logic signed [33:0] gain_term;
   logic signed [34:0] drive_sum;
   logic [23:0] drive_mag;
   logic [23:0] duty_raw;

   assign accept    = req_valid && !req_stall;
   assign req_stall = ctrl.busy;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign toggle    = req_data.button_level && !press_ff;

   esp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .op       (req_data.op),
      .toggle   (toggle),
      .rsp_free (rsp_free),
      .ctrl     (ctrl)
   );

   esp_mul u_mul (
      .clock     (clock),
      .sel_scale (ctrl.mul_scale),
      .error_q8  (error_ff),
      .kp_q8     (kp_ff),
      .drive_mag (drive_mag),
      .scale_q16 (scale_ff),
      .prod_ff   (prod)
   );

   // Encoder edges and button samples are handled on the accepting edge.
   always_comb begin
      pos_in    = pos_ff;
      enable_in = enable_ff;
      press_in  = press_ff;
      if (accept) begin
         if (req_data.op == esp_pkg::OP_EDGE) begin
            pos_in = req_data.b_level ? pos_ff + 32'd1 : pos_ff - 32'd1;
         end else if (req_data.op == esp_pkg::OP_BUTTON) begin
            if (toggle) begin
               enable_in = !enable_ff;
               press_in  = 1'b1;
            end else if (press_ff && !req_data.button_level) begin
               press_in = 1'b0;
            end
         end
      end
   end

   // Window speed and error; the count difference wraps modulo 2^32.
   always_comb begin
      diff = $signed(pos_ff - last_ff);
      if (diff > 32'sd32767) begin
         speed_in = 16'sh7fff;
      end else if (diff < -32'sd32768) begin
         speed_in = 16'sh8000;
      end else begin
         speed_in = diff[15:0];
      end
      err_wide = 26'(setpoint_ff) - (26'(speed_in) <<< 8);
      if (err_wide > 26'sd8388607) begin
         error_in = 24'sh7fffff;
      end else if (err_wide < -26'sd8388608) begin
         error_in = 24'sh800000;
      end else begin
         error_in = err_wide[23:0];
      end
   end

   // Dropping the low eight bits floors the gain product towards minus infinity.
   always_comb begin
      gain_term = prod[esp_pkg::MUL_P_W-1:8];
      drive_sum = 35'(setpoint_ff) + 35'(gain_term);
      if (!enable_ff) begin
         drive_in = '0;
      end else if (drive_sum > 35'sd8388607) begin
         drive_in = 24'sh7fffff;
      end else if (drive_sum < -35'sd8388608) begin
         drive_in = 24'sh800000;
      end else begin
         drive_in = drive_sum[23:0];
      end
   end

   assign drive_mag = drive_ff[23] ? (~drive_ff + 24'd1) : drive_ff;

   // The scale product is never negative, so its upper bits are the duty.
   always_comb begin
      duty_raw = prod[39:16];
      if (duty_raw > {14'd0, range_ff}) begin
         duty_in = range_ff;
      end else begin
         duty_in = duty_raw[9:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= esp_pkg::SETPOINT_RESET;
         kp_ff        <= esp_pkg::KP_RESET;
         scale_ff     <= esp_pkg::SCALE_RESET;
         range_ff     <= esp_pkg::RANGE_RESET;
         pos_ff       <= '0;
         last_ff      <= '0;
         enable_ff    <= 1'b0;
         press_ff     <= 1'b0;
         speed_ff     <= '0;
         error_ff     <= '0;
         drive_ff     <= '0;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               esp_pkg::CSR_SETPOINT: setpoint_ff <= $signed(csr_wdata);
               esp_pkg::CSR_KP:       kp_ff       <= csr_wdata;
               esp_pkg::CSR_SCALE:    scale_ff    <= csr_wdata;
               esp_pkg::CSR_RANGE:    range_ff    <= csr_wdata[9:0];
               default:               kp_ff       <= kp_ff;
            endcase
         end
         pos_ff       <= pos_in;
         enable_ff    <= enable_in;
         press_ff     <= press_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctrl.speed_en) begin
            last_ff  <= pos_ff;
            speed_ff <= speed_in;
            error_ff <= error_in;
         end
         if (ctrl.drive_en) begin
            drive_ff <= drive_in;
         end
         if (ctrl.duty_en) begin
            duty_ff <= duty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_data_ff.duty           <= duty_ff;
         rsp_data_ff.direction      <= !(drive_ff > 24'sd0);
         rsp_data_ff.enabled        <= enable_ff;
         rsp_data_ff.measured_speed <= speed_ff;
         rsp_data_ff.speed_error    <= error_ff;
         rsp_data_ff.drive          <= drive_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ESP_ASSERT_NEXT(a_duty_limit, clock, reset, ctrl.duty_en, duty_ff <= range_ff, "duty above PWM range")
   `ESP_ASSERT_NEXT(a_drive_off, clock, reset, ctrl.drive_en && !enable_ff, drive_ff == 24'sd0, "drive not zero while disabled")
   `ESP_ASSERT_NEXT(a_window_mark, clock, reset, ctrl.speed_en, last_ff == pos_ff, "window mark not taken at tick")
   `ESP_ASSERT_NOW(a_no_overwrite, clock, reset, ctrl.rsp_load, !(rsp_valid_ff && rsp_stall), "result overwritten while stalled")

endmodule

// File: design/esp_mul.sv
// Shared signed multiplier with operand selection and a registered product.
module esp_mul (
   input  logic                                  clock,
   input  logic                                  sel_scale,
   input  logic signed [23:0]                    error_q8,
   input  logic [15:0]                           kp_q8,
   input  logic [23:0]                           drive_mag,
   input  logic [15:0]                           scale_q16,
   output logic signed [esp_pkg::MUL_P_W-1:0]    prod_ff
);

   logic signed [esp_pkg::MUL_A_W-1:0] a_sel;
   logic signed [esp_pkg::MUL_B_W-1:0] b_sel;
   logic signed [esp_pkg::MUL_P_W-1:0] prod_in;

   always_comb begin
      if (sel_scale) begin
         a_sel = $signed({1'b0, drive_mag});
         b_sel = $signed({1'b0, scale_q16});
      end else begin
         a_sel = $signed({error_q8[23], error_q8});
         b_sel = $signed({1'b0, kp_q8});
      end
      prod_in = esp_pkg::MUL_P_W'(a_sel) * esp_pkg::MUL_P_W'(b_sel);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: design/esp_seq.sv
// Sequencer that steps one item through the shared multiplier.
module esp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            op,
   input  logic                  toggle,
   input  logic                  rsp_free,
   output esp_pkg::esp_ctrl_type ctrl
);

   esp_pkg::esp_state_type state_ff;
   esp_pkg::esp_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         esp_pkg::ST_IDLE: begin
            if (start) begin
               if (op == esp_pkg::OP_TICK) begin
                  state_in = esp_pkg::ST_SPEED;
               end else if (op == esp_pkg::OP_BUTTON && toggle) begin
                  state_in = esp_pkg::ST_GAIN;
               end else begin
                  state_in = esp_pkg::ST_DONE;
               end
            end
         end
         esp_pkg::ST_SPEED: state_in = esp_pkg::ST_GAIN;
         esp_pkg::ST_GAIN:  state_in = esp_pkg::ST_DRIVE;
         esp_pkg::ST_DRIVE: state_in = esp_pkg::ST_SCALE;
         esp_pkg::ST_SCALE: state_in = esp_pkg::ST_DUTY;
         esp_pkg::ST_DUTY:  state_in = esp_pkg::ST_DONE;
         esp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = esp_pkg::ST_IDLE;
            end
         end
         default: state_in = esp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.busy      = 1'b1;
      case (state_ff)
         esp_pkg::ST_IDLE:  ctrl.busy      = 1'b0;
         esp_pkg::ST_SPEED: ctrl.speed_en  = 1'b1;
         esp_pkg::ST_GAIN:  ctrl.mul_scale = 1'b0;
         esp_pkg::ST_DRIVE: ctrl.drive_en  = 1'b1;
         esp_pkg::ST_SCALE: ctrl.mul_scale = 1'b1;
         esp_pkg::ST_DUTY:  ctrl.duty_en   = 1'b1;
         esp_pkg::ST_DONE:  ctrl.rsp_load  = rsp_free;
         default:           ctrl.busy      = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the encoder speed controller top level.
module testbench;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int SETTLE_CYCLES = 16;
   localparam longint S24_MAX = 64'sd8388607;
   localparam longint S24_MIN = -64'sd8388608;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   esp_pkg::esp_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   esp_pkg::esp_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = esp_pkg::CSR_SETPOINT;
   logic [15:0]          csr_wdata = '0;

   encoder_speed_p_controller_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Controller settings as the block should hold them.
   logic signed [15:0] cfg_setpoint = esp_pkg::SETPOINT_RESET;
   logic [15:0]        cfg_kp = esp_pkg::KP_RESET;
   logic [15:0]        cfg_scale = esp_pkg::SCALE_RESET;
   logic [9:0]         cfg_range = esp_pkg::RANGE_RESET;

   // Controller state as the block should hold it.
   logic [31:0]        enc_count = '0;
   logic [31:0]        window_base = '0;
   logic               run_on = 1'b0;
   logic               press_held = 1'b0;
   logic signed [15:0] speed_q = '0;
   logic signed [23:0] error_q = '0;
   logic signed [23:0] drive_q = '0;
   logic [9:0]         duty_q = '0;

   esp_pkg::esp_req_type pending_beats[$];
   esp_pkg::esp_rsp_type awaited_status[$];
   esp_pkg::esp_rsp_type status_want;
   int          open_items = 0;
   int          mismatches = 0;
   int          gap_left = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   bit          allow_idle = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp24(input longint v);
      if (v > S24_MAX) return S24_MAX;
      if (v < S24_MIN) return S24_MIN;
      return v;
   endfunction

   // Drive and duty follow from the held error, the enable and the gains.
   function automatic void refresh_drive();
      longint prod;
      longint d;
      longint mag;
      longint dty;
      d = 0;
      if (run_on) begin
         prod = longint'(cfg_kp) * longint'(error_q);
         d = clamp24(longint'(cfg_setpoint) + (prod >>> 8));
      end
      mag = (d < 0) ? -d : d;
      dty = (mag * longint'(cfg_scale)) >> 16;
      if (dty > longint'(cfg_range)) dty = longint'(cfg_range);
      drive_q = 24'(d);
      duty_q = 10'(dty);
   endfunction

   function automatic void controller_step(input esp_pkg::esp_req_type beat);
      logic [31:0]          delta;
      longint               diff;
      esp_pkg::esp_rsp_type status;
      case (beat.op)
         esp_pkg::OP_EDGE: begin
            enc_count = beat.b_level ? enc_count + 32'd1 : enc_count - 32'd1;
         end
         esp_pkg::OP_TICK: begin
            delta = enc_count - window_base;
            diff = longint'(signed'(delta));
            if (diff > 32767) diff = 32767;
            if (diff < -32768) diff = -32768;
            window_base = enc_count;
            speed_q = 16'(diff);
            error_q = 24'(clamp24(longint'(cfg_setpoint) - diff * 256));
            refresh_drive();
         end
         esp_pkg::OP_BUTTON: begin
            if (beat.button_level && !press_held) begin
               run_on = !run_on;
               press_held = 1'b1;
               refresh_drive();
            end else if (press_held && !beat.button_level) begin
               press_held = 1'b0;
            end
         end
         default: begin
         end
      endcase
      status.duty = duty_q;
      status.direction = (drive_q > 0) ? 1'b0 : 1'b1;
      status.enabled = run_on;
      status.measured_speed = speed_q;
      status.speed_error = error_q;
      status.drive = drive_q;
      awaited_status.push_back(status);
   endfunction

   function automatic void queue_beat(input logic [1:0] op, input logic b, input logic btn);
      esp_pkg::esp_req_type beat;
      beat.op = op;
      beat.b_level = b;
      beat.button_level = btn;
      pending_beats.push_back(beat);
      open_items++;
   endfunction

   // Request driver: beats go out in order, with short random gaps while allow_idle is set.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) controller_step(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && allow_idle && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 3);
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: each accepted beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_status.size() == 0) begin
               $error("result beat arrived with no prediction waiting");
               mismatches++;
            end else begin
               status_want = awaited_status.pop_front();
               if (rsp_data.duty !== status_want.duty) begin
                  $error("duty: expected %0d, actual %0d", status_want.duty, rsp_data.duty);
                  mismatches++;
               end
               if (rsp_data.direction !== status_want.direction) begin
                  $error("direction: expected %0d, actual %0d",
                         status_want.direction, rsp_data.direction);
                  mismatches++;
               end
               if (rsp_data.enabled !== status_want.enabled) begin
                  $error("enabled: expected %0d, actual %0d",
                         status_want.enabled, rsp_data.enabled);
                  mismatches++;
               end
               if (rsp_data.measured_speed !== status_want.measured_speed) begin
                  $error("measured_speed: expected %0d, actual %0d",
                         status_want.measured_speed, rsp_data.measured_speed);
                  mismatches++;
               end
               if (rsp_data.speed_error !== status_want.speed_error) begin
                  $error("speed_error: expected %0d, actual %0d",
                         status_want.speed_error, rsp_data.speed_error);
                  mismatches++;
               end
               if (rsp_data.drive !== status_want.drive) begin
                  $error("drive: expected %0d, actual %0d", status_want.drive, rsp_data.drive);
                  mismatches++;
               end
               if (open_items > 0) open_items--;
            end
         end
         if (hold_left == 0 && allow_idle && $urandom_range(0, 5) == 0)
            hold_left = $urandom_range(1, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         esp_pkg::CSR_SETPOINT: cfg_setpoint = signed'(value);
         esp_pkg::CSR_KP:       cfg_kp = value;
         esp_pkg::CSR_SCALE:    cfg_scale = value;
         esp_pkg::CSR_RANGE:    cfg_range = value[9:0];
         default: begin
         end
      endcase
   endtask

   // Wait until every predicted result has come back and the block is quiet.
   task automatic settle();
      while (open_items > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_settings();
      logic [15:0] v;
      logic [9:0]  r;
      case ($urandom_range(0, 3))
         0: v = 16'h8000;
         1: v = 16'h7FFF;
         2: v = 16'($urandom_range(0, 4096)) - 16'd2048;
         default: v = 16'($urandom);
      endcase
      write_register(esp_pkg::CSR_SETPOINT, v);
      case ($urandom_range(0, 3))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         2: v = 16'($urandom_range(0, 1024));
         default: v = 16'($urandom);
      endcase
      write_register(esp_pkg::CSR_KP, v);
      case ($urandom_range(0, 3))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         default: v = 16'($urandom);
      endcase
      write_register(esp_pkg::CSR_SCALE, v);
      case ($urandom_range(0, 3))
         0: r = 10'd0;
         1: r = 10'd1023;
         default: r = 10'($urandom_range(1, 1023));
      endcase
      // The upper write bits have no effect on the duty range.
      write_register(esp_pkg::CSR_RANGE, {6'($urandom), r});
   endtask

   // Windows of encoder edges closed by a tick, with button samples and unused ops mixed in.
   task automatic random_stretch(input int budget);
      int made;
      int span;
      int up_odds;
      made = 0;
      while (made < budget) begin
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
         up_odds = $urandom_range(0, 4);
         repeat (span) begin
            queue_beat(esp_pkg::OP_EDGE, $urandom_range(1, 4) <= up_odds,
                       1'($urandom_range(0, 1)));
            made++;
            if ($urandom_range(0, 7) == 0) begin
               queue_beat(esp_pkg::OP_BUTTON, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
               made++;
            end
            if ($urandom_range(0, 39) == 0) begin
               queue_beat(OP_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               made++;
            end
         end
         queue_beat(esp_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         made++;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Held values straight after reset, then enable and disable around ticks.
      queue_beat(OP_UNUSED, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_BUTTON, 1'b0, 1'b0);
      repeat (3) queue_beat(esp_pkg::OP_EDGE, 1'b1, 1'b0);
      queue_beat(esp_pkg::OP_EDGE, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_TICK, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_BUTTON, 1'b0, 1'b1);
      queue_beat(esp_pkg::OP_BUTTON, 1'b0, 1'b1);
      queue_beat(esp_pkg::OP_BUTTON, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_TICK, 1'b1, 1'b1);
      repeat (2) queue_beat(esp_pkg::OP_EDGE, 1'b0, 1'b1);
      queue_beat(esp_pkg::OP_TICK, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_EDGE, 1'b1, 1'b0);
      queue_beat(esp_pkg::OP_BUTTON, 1'b1, 1'b1);
      queue_beat(esp_pkg::OP_TICK, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_BUTTON, 1'b1, 1'b0);
      queue_beat(esp_pkg::OP_BUTTON, 1'b0, 1'b1);
      queue_beat(OP_UNUSED, 1'b1, 1'b1);
      queue_beat(esp_pkg::OP_EDGE, 1'b1, 1'b1);
      queue_beat(esp_pkg::OP_TICK, 1'b1, 1'b0);
      settle();

      // Top of every setting: drive saturates at the positive limit.
      write_register(esp_pkg::CSR_SETPOINT, 16'h7FFF);
      write_register(esp_pkg::CSR_KP, 16'hFFFF);
      write_register(esp_pkg::CSR_SCALE, 16'hFFFF);
      write_register(esp_pkg::CSR_RANGE, 16'd1023);
      queue_beat(esp_pkg::OP_EDGE, 1'b0, 1'b0);
      queue_beat(esp_pkg::OP_TICK, 1'b0, 1'b0);
      settle();

      // Bottom of every setting: zero gain, zero scale, zero duty range.
      write_register(esp_pkg::CSR_SETPOINT, 16'h8000);
      write_register(esp_pkg::CSR_KP, 16'h0000);
      write_register(esp_pkg::CSR_SCALE, 16'h0000);
      write_register(esp_pkg::CSR_RANGE, 16'd0);
      queue_beat(esp_pkg::OP_EDGE, 1'b1, 1'b0);
      queue_beat(esp_pkg::OP_TICK, 1'b0, 1'b0);
      settle();

      repeat (4) begin
         pick_settings();
         random_stretch(310);
         settle();
      end

      // The closing stretch runs with no idle cycles on either side.
      allow_idle = 1'b0;
      pick_settings();
      random_stretch(250);
      settle();

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
